@@ src/rpr_pkg.sv @@
// Shared types, widths and constants for the relative permutation rank unit.
// No dependencies; every other file in src imports this package.
`default_nettype none

package rpr_pkg;

	// Fixed field geometry
	localparam int MAX_LEN             = 10;
	localparam int CODE_W              = 4;
	localparam int PERM_W              = MAX_LEN * CODE_W;
	localparam int INDEX_W             = 22;
	localparam int DIGIT_W             = 4;
	localparam int PAIRS               = (MAX_LEN + 1) / 2;
	localparam int DEFAULT_PERM_LENGTH = 10;

	// Stream word widths, padded to whole bytes
	localparam int S_DATA_W = ((2 * PERM_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((INDEX_W + 7) / 8) * 8;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	// Relative permutation handed from the relabel stage to the rank stages
	typedef struct packed {
		logic                bad;
		code_t [MAX_LEN-1:0] rel;
	} relabel_t;

	// n! for the constant weights of the factorial number system
	function automatic index_t fact_of(input int n);
		int acc;
		acc = 1;
		for (int i = 2; i <= n; i++) begin
			acc = acc * i;
		end
		return INDEX_W'(acc);
	endfunction

endpackage

`default_nettype wire

@@ src/rpr_relabel.sv @@
// Validity check of both permutations and mapping of each destination symbol
// to its position in the source. Combinational; depends on rpr_pkg.
`default_nettype none

module rpr_relabel #(
	parameter int PERM_LENGTH = rpr_pkg::DEFAULT_PERM_LENGTH
) (
	input  wire logic [rpr_pkg::PERM_W-1:0] source_perm,
	input  wire logic [rpr_pkg::PERM_W-1:0] target_perm,
	output rpr_pkg::relabel_t               result
);
	import rpr_pkg::*;

	code_t [MAX_LEN-1:0] src_code;
	code_t [MAX_LEN-1:0] dst_code;
	logic                src_bad;
	logic                dst_bad;

	assign src_code = source_perm;
	assign dst_code = target_perm;

	// Flag codes out of range and repeated codes in the used positions
	always_comb begin
		src_bad = 1'b0;
		dst_bad = 1'b0;
		for (int i = 0; i < PERM_LENGTH; i++) begin
			if (src_code[i] >= CODE_W'(PERM_LENGTH)) src_bad = 1'b1;
			if (dst_code[i] >= CODE_W'(PERM_LENGTH)) dst_bad = 1'b1;
			for (int j = i + 1; j < PERM_LENGTH; j++) begin
				if (src_code[i] == src_code[j]) src_bad = 1'b1;
				if (dst_code[i] == dst_code[j]) dst_bad = 1'b1;
			end
		end
	end

	// Encode the matching source position of each destination symbol
	always_comb begin
		result.bad = src_bad | dst_bad;
		result.rel = '0;
		for (int i = 0; i < PERM_LENGTH; i++) begin
			for (int j = 0; j < PERM_LENGTH; j++) begin
				if (dst_code[i] == src_code[j]) begin
					result.rel[i] = result.rel[i] | CODE_W'(j);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/relative_permutation_rank_unit.sv @@
// Top level of the relative permutation rank unit: stream ports, pipeline
// control, factorial digits and weighted sum. Depends on rpr_pkg, rpr_relabel.
//
//  channel  | dir | tdata (low bit up)               | tuser
//  ---------+-----+----------------------------------+-----------
//  s_axis   | in  | source_perm[39:0], target_perm   | -
//  m_axis   | out | perm_index[21:0], 2 zero pad     | bad_input
//
// One word per cycle sustained while m_axis_tready holds high; after its word is taken,
// a result passes the input register, relabel register, pair-sum register and output register.
// Reset clears only the stage valid bits.
// Stalls: each stage loads when it is empty or the stage after it moves, so
// bubbles collapse and s_axis_tready stays high while any stage is empty.
`default_nettype none

module relative_permutation_rank_unit #(
	parameter int PERM_LENGTH = rpr_pkg::DEFAULT_PERM_LENGTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// source_perm [39:0], target_perm [79:40]
	input  wire logic [rpr_pkg::S_DATA_W-1:0] s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// perm_index [21:0], zero [23:22]
	output logic [rpr_pkg::M_DATA_W-1:0]      m_axis_tdata,
	// bad_input [0]
	output logic [0:0]                        m_axis_tuser
);
	import rpr_pkg::*;

	logic                 v_s1, v_s2, v_s3, out_valid_q;
	logic                 rdy1, rdy2, rdy3, rdy_out;
	logic [PERM_W-1:0]    src_s1, dst_s1;
	relabel_t             relabel;
	relabel_t             rel_s2;
	digit_t [MAX_LEN-1:0] digit;
	index_t [PAIRS-1:0]   pair_sum;
	index_t [PAIRS-1:0]   pair_s3;
	logic                 bad_s3;
	index_t               total;
	index_t               index_q;
	logic                 bad_q;

	// Ready runs back from the output register
	assign rdy_out       = !out_valid_q || m_axis_tready;
	assign rdy3          = !v_s3 || rdy_out;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// Advance the stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= s_axis_tvalid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			src_s1 <= s_axis_tdata[PERM_W-1:0];
			dst_s1 <= s_axis_tdata[2*PERM_W-1:PERM_W];
		end
	end

	rpr_relabel #(
		.PERM_LENGTH(PERM_LENGTH)
	) u_relabel (
		.source_perm(src_s1),
		.target_perm(dst_s1),
		.result     (relabel)
	);

	// Hold the relative permutation
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			rel_s2 <= relabel;
		end
	end

	// Count earlier smaller entries at each position
	always_comb begin
		logic [MAX_LEN-1:0] lt;
		for (int i = 0; i < MAX_LEN; i++) begin
			lt = '0;
			for (int k = 0; k < i; k++) begin
				if (i < PERM_LENGTH) lt[k] = rel_s2.rel[k] < rel_s2.rel[i];
			end
			digit[i] = DIGIT_W'($countones(lt));
		end
	end

	// Weight digits by i! and add them in pairs
	always_comb begin
		for (int p = 0; p < PAIRS; p++) begin
			pair_sum[p] = INDEX_W'(digit[2*p]) * fact_of(2 * p);
			if (2 * p + 1 < MAX_LEN) begin
				pair_sum[p] = pair_sum[p] + INDEX_W'(digit[2*p+1]) * fact_of(2 * p + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			pair_s3 <= pair_sum;
			bad_s3  <= rel_s2.bad;
		end
	end

	// Final sum; drop the rank of a bad word
	always_comb begin
		total = '0;
		for (int p = 0; p < PAIRS; p++) begin
			total = total + pair_s3[p];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			index_q <= bad_s3 ? '0 : total;
			bad_q   <= bad_s3;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = M_DATA_W'(index_q);
	assign m_axis_tuser[0] = bad_q;

	// A flagged word carries a zero rank
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[INDEX_W-1:0] == '0)
		else $error("bad word with nonzero rank");

	// The rank stays below PERM_LENGTH!
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[INDEX_W-1:0] < fact_of(PERM_LENGTH))
		else $error("rank out of range");

	// An accepted word lands in the input register
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted word lost at input");

	// A blocked middle stage keeps its word
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(rel_s2))
		else $error("stalled relabel stage changed");

	// A blocked pair-sum stage keeps its word
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy_out |=> v_s3 && $stable(pair_s3))
		else $error("stalled pair-sum stage changed");

endmodule

`default_nettype wire
